// ===== hw/rtl/nbc_pkg.sv =====
// Shared constants, types and helpers for the two-feature naive Bayes classifier.
package nbc_pkg;

    localparam int LEVEL_CATEGORIES = 4;
    localparam int HOUR_CATEGORIES  = 24;
    localparam int COUNT_BITS       = 16;

    localparam int LEVEL_BITS = 2;
    localparam int HOUR_BITS  = 5;

    // A factor is a count plus one or a total plus a category count.
    localparam int FACTOR_BITS     = COUNT_BITS + 1;
    localparam int NUM_FACTORS     = 5;
    localparam int FACTOR_IDX_BITS = 3;
    localparam int LIMB_BITS       = 32;
    localparam int PRODUCT_BITS    = NUM_FACTORS * FACTOR_BITS;
    localparam int NUM_LIMBS       = (PRODUCT_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int ACC_BITS        = NUM_LIMBS * LIMB_BITS;
    localparam int LIMB_IDX_BITS   = (NUM_LIMBS > 1) ? $clog2(NUM_LIMBS) : 1;

    localparam int LEVEL_ENTRIES   = 2 * LEVEL_CATEGORIES;
    localparam int HOUR_ENTRIES    = 2 * HOUR_CATEGORIES;
    localparam int LEVEL_ADDR_BITS = $clog2(LEVEL_ENTRIES);
    localparam int HOUR_ADDR_BITS  = $clog2(HOUR_ENTRIES);

    localparam logic REQ_TRAIN = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [FACTOR_BITS-1:0] factor_t;
    typedef logic [LIMB_BITS-1:0]   limb_t;

    typedef struct packed {
        logic                       rd_en;
        logic                       wr_en;
        logic                       cls;
        logic [LEVEL_ADDR_BITS-1:0] lvl_addr;
        logic [HOUR_ADDR_BITS-1:0]  hour_addr;
    } store_ctl_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : count_t'(v + count_t'(1));
    endfunction

endpackage

// ===== hw/rtl/nbc_count_store.sv =====
// Frequency tables, their valid bits and the per-class totals.
module nbc_count_store (
    input  logic                clk,
    input  logic                rst_n,
    input  nbc_pkg::store_ctl_t ctl,
    output nbc_pkg::count_t     lvl_cnt,
    output nbc_pkg::count_t     hour_cnt,
    output nbc_pkg::count_t     total0,
    output nbc_pkg::count_t     total1
);

    nbc_pkg::count_t lvl_mem  [nbc_pkg::LEVEL_ENTRIES];
    nbc_pkg::count_t hour_mem [nbc_pkg::HOUR_ENTRIES];

    logic [nbc_pkg::LEVEL_ENTRIES-1:0] lvl_vld_reg;
    logic [nbc_pkg::HOUR_ENTRIES-1:0]  hour_vld_reg;
    logic                              lvl_vq_reg;
    logic                              hour_vq_reg;
    nbc_pkg::count_t                   lvl_q_reg;
    nbc_pkg::count_t                   hour_q_reg;
    nbc_pkg::count_t                   total_reg [2];

    // An entry that was never written reads as zero.
    assign lvl_cnt  = lvl_vq_reg  ? lvl_q_reg  : '0;
    assign hour_cnt = hour_vq_reg ? hour_q_reg : '0;
    assign total0   = total_reg[0];
    assign total1   = total_reg[1];

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            lvl_q_reg  <= lvl_mem[ctl.lvl_addr];
            hour_q_reg <= hour_mem[ctl.hour_addr];
        end
        if (ctl.wr_en)
        begin
            lvl_mem[ctl.lvl_addr]   <= nbc_pkg::sat_inc(lvl_cnt);
            hour_mem[ctl.hour_addr] <= nbc_pkg::sat_inc(hour_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_vld_reg  <= '0;
            hour_vld_reg <= '0;
            lvl_vq_reg   <= 1'b0;
            hour_vq_reg  <= 1'b0;
            total_reg[0] <= '0;
            total_reg[1] <= '0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                lvl_vq_reg  <= lvl_vld_reg[ctl.lvl_addr];
                hour_vq_reg <= hour_vld_reg[ctl.hour_addr];
            end
            if (ctl.wr_en)
            begin
                lvl_vld_reg[ctl.lvl_addr]   <= 1'b1;
                hour_vld_reg[ctl.hour_addr] <= 1'b1;
                total_reg[ctl.cls]          <= nbc_pkg::sat_inc(total_reg[ctl.cls]);
            end
        end
    end

endmodule

// ===== hw/rtl/nbc_limb_mac.sv =====
// Shared multiply-accumulate step: one accumulator limb times a factor plus carry.
module nbc_limb_mac (
    input  nbc_pkg::limb_t   limb,
    input  nbc_pkg::factor_t fac,
    input  nbc_pkg::factor_t carry_in,
    output nbc_pkg::limb_t   limb_out,
    output nbc_pkg::factor_t carry_out
);

    localparam int SUM_BITS = nbc_pkg::LIMB_BITS + nbc_pkg::FACTOR_BITS;

    logic [SUM_BITS-1:0] prod;
    logic [SUM_BITS-1:0] sum;

    // The sum stays below 2^32 times the factor, so the carry fits a factor.
    assign prod      = SUM_BITS'(limb) * SUM_BITS'(fac);
    assign sum       = prod + SUM_BITS'(carry_in);
    assign limb_out  = sum[nbc_pkg::LIMB_BITS-1:0];
    assign carry_out = sum[SUM_BITS-1:nbc_pkg::LIMB_BITS];

endmodule

// ===== hw/rtl/naive_bayes_two_feature_classifier_unit.sv =====
// Top level of the two-feature naive Bayes classifier with its sequencer.
//
// Requests enter on in_valid/in_ready with req_type, light_level, hour and
// label. A train request adds one labelled sample to the frequency tables
// and class totals (all counters saturate) and gives no result. A query
// request gives one predicted_label on out_valid/out_ready.
// The block takes one request at a time; in_ready is high only when idle.
// A train request goes through S_READ and S_LOAD and then back to idle.
// A query reads both classes' counts, then builds the products
// N0*D1 and N1*D0 limb by limb on one shared 32-bit by factor multiplier,
// after which predicted_label shows and in_ready rises in the same cycle.
// The result sits in an output register, so the next request is taken
// while it waits; a second query result is held back until it is taken.
// Reset clears the tables through valid bits and the totals at once; no
// clearing pass is needed and the block is ready right after reset.
module naive_bayes_two_feature_classifier_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [nbc_pkg::LEVEL_BITS-1:0]  light_level,
    input  logic [nbc_pkg::HOUR_BITS-1:0]   hour,
    input  logic                            label,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            predicted_label
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LOAD = 6'b000100,
        S_INIT = 6'b001000,
        S_MUL  = 6'b010000,
        S_CMP  = 6'b100000
    } state_t;

    localparam int FI = nbc_pkg::FACTOR_IDX_BITS;
    localparam int LI = nbc_pkg::LIMB_IDX_BITS;
    localparam int AB = nbc_pkg::ACC_BITS;
    localparam int LB = nbc_pkg::LIMB_BITS;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   pred_reg, pred_next;

    logic                           req_reg, req_next;
    logic [nbc_pkg::LEVEL_BITS-1:0] lv_reg, lv_next;
    logic [nbc_pkg::HOUR_BITS-1:0]  hr_reg, hr_next;
    logic                           cls_reg, cls_next;
    logic                           lv_ok_reg, lv_ok_next;
    logic                           hr_ok_reg, hr_ok_next;
    nbc_pkg::count_t                lcnt_reg [2];
    nbc_pkg::count_t                lcnt_next [2];
    nbc_pkg::count_t                hcnt_reg [2];
    nbc_pkg::count_t                hcnt_next [2];
    logic                           side_reg, side_next;
    logic [FI-1:0]                  k_reg, k_next;
    logic [LI-1:0]                  limb_reg, limb_next;
    nbc_pkg::factor_t               fac_reg, fac_next;
    nbc_pkg::factor_t               carry_reg, carry_next;
    logic [AB-1:0]                  acc_reg, acc_next;
    logic [AB-1:0]                  left_reg, left_next;

    nbc_pkg::store_ctl_t st_ctl;
    nbc_pkg::count_t     st_lvl;
    nbc_pkg::count_t     st_hour;
    nbc_pkg::count_t     st_total0;
    nbc_pkg::count_t     st_total1;
    nbc_pkg::limb_t      mac_limb;
    nbc_pkg::factor_t    mac_carry;
    logic [AB-1:0]       acc_shift;
    logic                accept;

    // Side 0 builds N0*D1, side 1 builds N1*D0, one factor per index.
    function automatic nbc_pkg::factor_t pick_factor(
        input logic          side,
        input logic [FI-1:0] k,
        input nbc_pkg::count_t l0,
        input nbc_pkg::count_t h0,
        input nbc_pkg::count_t t0,
        input nbc_pkg::count_t l1,
        input nbc_pkg::count_t h1,
        input nbc_pkg::count_t t1
    );
        nbc_pkg::count_t  l_own;
        nbc_pkg::count_t  h_own;
        nbc_pkg::count_t  t_own;
        nbc_pkg::count_t  t_oth;
        nbc_pkg::factor_t f;
        l_own = side ? l1 : l0;
        h_own = side ? h1 : h0;
        t_own = side ? t1 : t0;
        t_oth = side ? t0 : t1;
        case (k)
            3'd0:    f = nbc_pkg::FACTOR_BITS'(l_own) + nbc_pkg::FACTOR_BITS'(1);
            3'd1:    f = nbc_pkg::FACTOR_BITS'(h_own) + nbc_pkg::FACTOR_BITS'(1);
            3'd2:    f = nbc_pkg::FACTOR_BITS'(t_own) + nbc_pkg::FACTOR_BITS'(1);
            3'd3:    f = nbc_pkg::FACTOR_BITS'(t_oth)
                         + nbc_pkg::FACTOR_BITS'(nbc_pkg::LEVEL_CATEGORIES);
            3'd4:    f = nbc_pkg::FACTOR_BITS'(t_oth)
                         + nbc_pkg::FACTOR_BITS'(nbc_pkg::HOUR_CATEGORIES);
            default: f = '0;
        endcase
        return f;
    endfunction

    nbc_count_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (st_ctl),
        .lvl_cnt  (st_lvl),
        .hour_cnt (st_hour),
        .total0   (st_total0),
        .total1   (st_total1)
    );

    nbc_limb_mac u_mac (
        .limb      (acc_reg[LB-1:0]),
        .fac       (fac_reg),
        .carry_in  (carry_reg),
        .limb_out  (mac_limb),
        .carry_out (mac_carry)
    );

    assign in_ready        = (state_reg == S_IDLE);
    assign accept          = in_valid && in_ready;
    assign out_valid       = out_valid_reg;
    assign predicted_label = pred_reg;

    // The accumulator rotates one limb per step, least significant limb first.
    assign acc_shift = {mac_limb, acc_reg[AB-1:LB]};

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pred_next      = pred_reg;
        req_next       = req_reg;
        lv_next        = lv_reg;
        hr_next        = hr_reg;
        cls_next       = cls_reg;
        lv_ok_next     = lv_ok_reg;
        hr_ok_next     = hr_ok_reg;
        lcnt_next      = lcnt_reg;
        hcnt_next      = hcnt_reg;
        side_next      = side_reg;
        k_next         = k_reg;
        limb_next      = limb_reg;
        fac_next       = fac_reg;
        carry_next     = carry_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;

        st_ctl           = '0;
        st_ctl.cls       = cls_reg;
        st_ctl.lvl_addr  = nbc_pkg::LEVEL_ADDR_BITS'({lv_reg, cls_reg});
        st_ctl.hour_addr = nbc_pkg::HOUR_ADDR_BITS'({hr_reg, cls_reg});

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req_type;
                    lv_next    = light_level;
                    hr_next    = hour;
                    cls_next   = (req_type == nbc_pkg::REQ_TRAIN) ? label : 1'b0;
                    lv_ok_next = (32'(light_level) < nbc_pkg::LEVEL_CATEGORIES);
                    hr_ok_next = (32'(hour) < nbc_pkg::HOUR_CATEGORIES);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                st_ctl.rd_en = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                if (req_reg == nbc_pkg::REQ_TRAIN)
                begin
                    // An out-of-range sample leaves every counter untouched.
                    st_ctl.wr_en = lv_ok_reg && hr_ok_reg;
                    state_next   = S_IDLE;
                end
                else
                begin
                    lcnt_next[cls_reg] = lv_ok_reg ? st_lvl : '0;
                    hcnt_next[cls_reg] = hr_ok_reg ? st_hour : '0;
                    if (!cls_reg)
                    begin
                        cls_next   = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                acc_next   = AB'(pick_factor(side_reg, FI'(0), lcnt_reg[0], hcnt_reg[0],
                                             st_total0, lcnt_reg[1], hcnt_reg[1],
                                             st_total1));
                fac_next   = pick_factor(side_reg, FI'(1), lcnt_reg[0], hcnt_reg[0],
                                         st_total0, lcnt_reg[1], hcnt_reg[1], st_total1);
                k_next     = FI'(1);
                limb_next  = '0;
                carry_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next   = acc_shift;
                carry_next = mac_carry;
                limb_next  = limb_reg + LI'(1);
                if (limb_reg == LI'(nbc_pkg::NUM_LIMBS - 1))
                begin
                    limb_next  = '0;
                    carry_next = '0;
                    if (k_reg == FI'(nbc_pkg::NUM_FACTORS - 1))
                    begin
                        if (!side_reg)
                        begin
                            left_next  = acc_shift;
                            side_next  = 1'b1;
                            state_next = S_INIT;
                        end
                        else
                        begin
                            state_next = S_CMP;
                        end
                    end
                    else
                    begin
                        k_next   = k_reg + FI'(1);
                        fac_next = pick_factor(side_reg, k_reg + FI'(1), lcnt_reg[0],
                                               hcnt_reg[0], st_total0, lcnt_reg[1],
                                               hcnt_reg[1], st_total1);
                    end
                end
            end
            S_CMP:
            begin
                // Hold the new result back while the previous one waits.
                if (!out_valid_reg || out_ready)
                begin
                    pred_next      = (left_reg > acc_reg) ? 1'b0 : 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pred_reg    <= pred_next;
        req_reg     <= req_next;
        lv_reg      <= lv_next;
        hr_reg      <= hr_next;
        cls_reg     <= cls_next;
        lv_ok_reg   <= lv_ok_next;
        hr_ok_reg   <= hr_ok_next;
        lcnt_reg    <= lcnt_next;
        hcnt_reg    <= hcnt_next;
        side_reg    <= side_next;
        k_reg       <= k_next;
        limb_reg    <= limb_next;
        fac_reg     <= fac_next;
        carry_reg   <= carry_next;
        acc_reg     <= acc_next;
        left_reg    <= left_next;
    end

endmodule

// ===== hw/rtl/nbc_checker.sv =====
// Port-level checks of the classifier's request and result timing, bound to the top level.
module nbc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            req_type,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            predicted_label
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(predicted_label))
        else $error("result changed or dropped while stalled");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in work");

    // A train request never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == nbc_pkg::REQ_TRAIN) |=> !$rose(out_valid))
        else $error("result appeared after a train request");

    // A new result appears exactly when the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while a request was still in work");

endmodule

bind naive_bayes_two_feature_classifier_unit nbc_checker u_nbc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .predicted_label (predicted_label)
);
